// ===== rtl/core/ggc_pkg.sv =====
package ggc_pkg;

    localparam int MaxNodes  = 16;
    localparam int NodeW     = $clog2(MaxNodes);
    localparam int ColorW    = 4;
    localparam int NumColors = 1 << ColorW;
    localparam int CountW    = 5;

    typedef logic [NodeW-1:0]    node_t;
    typedef logic [ColorW-1:0]   color_t;
    typedef logic [MaxNodes-1:0] row_t;
    typedef logic [CountW-1:0]   count_t;

    localparam logic REQ_EDGE  = 1'b0;
    localparam logic REQ_COLOR = 1'b1;

    typedef struct packed {
        logic edge_wr;
        logic pass_start;
        logic color_step;
    } ggc_cmd_t;

    typedef struct packed {
        logic at_last;
    } ggc_stat_t;

endpackage

// ===== rtl/core/greedy_graph_coloring.sv =====
// Channel   Handshake                 Payload
// request   start, busy               req_type, node_a, node_b
// config    cfg_valid, cfg_ready      cfg_data (node_count)
// result    result_valid (strobe)     node_index, node_color, last_node
//
// An edge word is stored at the accepting edge if both of its nodes lie within node_count.
// A color request is accepted from idle, then holds busy while n nodes are colored, where n is
// node_count limited to 1..16, one node per cycle through the lowest-free-color unit.
// Each result word follows in the cycle after its node is colored, one per cycle.
// A config word is taken only while no pass runs and start is low.
// Reset clears the adjacency matrix and sets node_count to 16.
// The receiver cannot stall; each result word stands for exactly one cycle.
module greedy_graph_coloring (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               req_type,
    input  ggc_pkg::node_t     node_a,
    input  ggc_pkg::node_t     node_b,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  ggc_pkg::count_t    cfg_data,
    output logic               result_valid,
    output ggc_pkg::node_t     node_index,
    output ggc_pkg::color_t    node_color,
    output logic               last_node
);
    import ggc_pkg::*;

    ggc_cmd_t  cmd;
    ggc_stat_t stat;
    logic      cfg_wr;

    assign cfg_ready = !busy && !start;
    assign cfg_wr    = cfg_valid && cfg_ready;

    ggc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .stat     (stat),
        .cmd      (cmd),
        .busy     (busy)
    );

    ggc_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_valid    (cfg_wr),
        .cfg_data     (cfg_data),
        .node_a       (node_a),
        .node_b       (node_b),
        .result_valid (result_valid),
        .node_index   (node_index),
        .node_color   (node_color),
        .last_node    (last_node)
    );

    a_result_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result word without a coloring pass");

    a_pass_ends_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> (result_valid && last_node))
        else $error("coloring pass ended without the last word");

    a_index_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last_node) |=>
            (result_valid && (node_index == $past(node_index) + node_t'(1))))
        else $error("result words out of node order");

    a_first_color: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (node_index == '0)) |-> (node_color == '0))
        else $error("node 0 not given color 0");

endmodule

// ===== rtl/core/ggc_ctrl.sv =====
module ggc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              req_type,
    input  ggc_pkg::ggc_stat_t stat,
    output ggc_pkg::ggc_cmd_t  cmd,
    output logic              busy
);
    import ggc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_COLOR = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd.edge_wr    = 1'b0;
        cmd.pass_start = 1'b0;
        cmd.color_step = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (req_type == REQ_COLOR)
                    begin
                        cmd.pass_start = 1'b1;
                        state_next     = S_COLOR;
                    end
                    else
                    begin
                        cmd.edge_wr = 1'b1;
                    end
                end
            end
            S_COLOR:
            begin
                cmd.color_step = 1'b1;
                if (stat.at_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg == S_COLOR);

endmodule

// ===== rtl/core/ggc_dp.sv =====
module ggc_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  ggc_pkg::ggc_cmd_t  cmd,
    output ggc_pkg::ggc_stat_t stat,
    input  logic               cfg_valid,
    input  ggc_pkg::count_t    cfg_data,
    input  ggc_pkg::node_t     node_a,
    input  ggc_pkg::node_t     node_b,
    output logic               result_valid,
    output ggc_pkg::node_t     node_index,
    output ggc_pkg::color_t    node_color,
    output logic               last_node
);
    import ggc_pkg::*;

    count_t  count_reg;
    node_t   last_idx;
    row_t    adj_reg [MaxNodes];
    color_t  color_reg [MaxNodes];
    node_t   idx_reg;
    node_t   idx_next;
    row_t    cur_row;
    logic [NumColors-1:0] used;
    color_t  free_color;
    logic    res_valid_reg;
    node_t   res_idx_reg;
    color_t  res_color_reg;
    logic    res_last_reg;

    always_comb
    begin
        if (count_reg == '0)
        begin
            last_idx = '0;
        end
        else if (count_reg > count_t'(MaxNodes))
        begin
            last_idx = node_t'(MaxNodes - 1);
        end
        else
        begin
            last_idx = node_t'(count_reg - count_t'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= count_t'(MaxNodes);
        end
        else if (cfg_valid)
        begin
            count_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < MaxNodes; r++)
            begin
                adj_reg[r] <= '0;
            end
        end
        else if (cmd.edge_wr && (node_a <= last_idx) && (node_b <= last_idx))
        begin
            for (int r = 0; r < MaxNodes; r++)
            begin
                if (node_t'(r) == node_a)
                begin
                    adj_reg[r][node_b] <= 1'b1;
                end
                if (node_t'(r) == node_b)
                begin
                    adj_reg[r][node_a] <= 1'b1;
                end
            end
        end
    end

    assign cur_row = adj_reg[idx_reg];

    always_comb
    begin
        used = '0;
        for (int v = 0; v < MaxNodes; v++)
        begin
            if (cur_row[v] && (node_t'(v) < idx_reg))
            begin
                used[color_reg[v]] = 1'b1;
            end
        end
    end

    always_comb
    begin
        free_color = color_t'(NumColors - 1);
        for (int c = NumColors - 2; c >= 0; c--)
        begin
            if (!used[c])
            begin
                free_color = color_t'(c);
            end
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.pass_start)
        begin
            idx_next = '0;
        end
        else if (cmd.color_step)
        begin
            idx_next = idx_reg + node_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            res_valid_reg <= cmd.color_step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.color_step)
        begin
            color_reg[idx_reg] <= free_color;
            res_idx_reg        <= idx_reg;
            res_color_reg      <= free_color;
            res_last_reg       <= stat.at_last;
        end
    end

    assign stat.at_last = (idx_reg == last_idx);
    assign result_valid = res_valid_reg;
    assign node_index   = res_idx_reg;
    assign node_color   = res_color_reg;
    assign last_node    = res_last_reg;

endmodule
